// ----- hdl/udqr_pkg.sv -----
package udqr_pkg;

    localparam int unsigned DIV_WIDTH = 32;
    localparam int unsigned CNT_W     = $clog2(DIV_WIDTH);

    typedef logic [DIV_WIDTH-1:0] t_word;

    typedef struct packed {
        logic load;
        logic step;
        logic capture;
    } t_dp_cmd;

    typedef struct packed {
        logic den_zero;
    } t_dp_sts;

endpackage

// ----- hdl/udqr_if.sv -----
interface udqr_req_if;
    import udqr_pkg::*;

    logic  valid;
    logic  ready;
    t_word dividend;
    t_word divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface udqr_rsp_if;
    import udqr_pkg::*;

    logic  valid;
    logic  ready;
    t_word quotient;
    t_word remainder;
    logic  divide_by_zero;

    modport source (output valid, output quotient, output remainder, output divide_by_zero,
                    input ready);
    modport sink   (input valid, input quotient, input remainder, input divide_by_zero,
                    output ready);
endinterface

// ----- hdl/udqr_dpath.sv -----
module udqr_dpath (
    input  logic              i_clk,
    input  udqr_pkg::t_dp_cmd i_cmd,
    output udqr_pkg::t_dp_sts o_sts,
    input  udqr_pkg::t_word   i_dividend,
    input  udqr_pkg::t_word   i_divisor,
    output udqr_pkg::t_word   o_quotient,
    output udqr_pkg::t_word   o_remainder,
    output logic              o_divide_by_zero
);
    import udqr_pkg::*;

    t_word r_rem;
    t_word r_quo;
    t_word r_den;
    logic  r_dbz;
    t_word r_out_quo;
    t_word r_out_rem;
    logic  r_out_dbz;

    logic                 carry;
    t_word                shifted;
    logic [DIV_WIDTH+1:0] diff;
    logic                 take;

    assign carry   = r_rem[DIV_WIDTH-1];
    assign shifted = {r_rem[DIV_WIDTH-2:0], r_quo[DIV_WIDTH-1]};
    assign diff    = {1'b0, carry, shifted} - {2'b00, r_den};
    assign take    = ~diff[DIV_WIDTH+1];

    assign o_sts.den_zero = (i_divisor == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_den <= i_divisor;
            r_dbz <= o_sts.den_zero;
            if (o_sts.den_zero) begin
                r_rem <= i_dividend;
                r_quo <= '0;
            end else begin
                r_rem <= '0;
                r_quo <= i_dividend;
            end
        end else if (i_cmd.step) begin
            r_rem <= take ? diff[DIV_WIDTH-1:0] : shifted;
            r_quo <= {r_quo[DIV_WIDTH-2:0], take};
        end
        if (i_cmd.capture) begin
            r_out_quo <= r_quo;
            r_out_rem <= r_rem;
            r_out_dbz <= r_dbz;
        end
    end

    assign o_quotient       = r_out_quo;
    assign o_remainder      = r_out_rem;
    assign o_divide_by_zero = r_out_dbz;

endmodule

// ----- hdl/udqr_ctrl.sv -----
module udqr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output udqr_pkg::t_dp_cmd o_cmd,
    input  udqr_pkg::t_dp_sts i_sts
);
    import udqr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_rsp_valid;

    assign o_req_ready   = (r_state == S_IDLE);
    assign o_cmd.load    = i_req_valid && o_req_ready;
    assign o_cmd.step    = (r_state == S_RUN);
    assign o_cmd.capture = (r_state == S_HOLD) && (!r_rsp_valid || i_rsp_ready);
    assign o_rsp_valid   = r_rsp_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (o_cmd.capture) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.load) begin
                        r_cnt   <= CNT_W'(DIV_WIDTH - 1);
                        r_state <= i_sts.den_zero ? S_HOLD : S_RUN;
                    end
                end
                S_RUN: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (o_cmd.capture) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hdl/unsigned_divider_quotient_remainder_unit.sv -----
// Channel   Dir  Handshake      Payload
// i_req     in   valid/ready    dividend, divisor
// o_rsp     out  valid/ready    quotient, remainder, divide_by_zero
//
// One request at a time; restoring division, one quotient bit per cycle.
// Non-zero divisor: load, then one step per quotient bit (DIV_WIDTH steps), then capture.
// Zero divisor skips the steps: load, then capture.
// Result register lets the next request start while a response waits.
// Synchronous active-low reset clears control only.
module unsigned_divider_quotient_remainder_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    udqr_req_if.sink   i_req,
    udqr_rsp_if.source o_rsp
);
    import udqr_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    udqr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    udqr_dpath u_dpath (
        .i_clk            (i_clk),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_dividend       (i_req.dividend),
        .i_divisor        (i_req.divisor),
        .o_quotient       (o_rsp.quotient),
        .o_remainder      (o_rsp.remainder),
        .o_divide_by_zero (o_rsp.divide_by_zero)
    );

    a_zero_quotient: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.divide_by_zero) |-> (o_rsp.quotient == '0))
        else $error("quotient not zero on divide by zero");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while busy");

    a_rsp_from_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> !$past(i_req.ready))
        else $error("response raised without a request in flight");

endmodule
